// File: hw/rtl/fpbm_pkg.sv
// Package for the FSK pulse-burst modulator.
// Holds command and register codes, reset values and the shared structs.
// Used by every other file of the block but fpbm_out_if; depends on nothing.
`timescale 1ns / 1ps

package fpbm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned CFG_TIME_W = 16;
  localparam int unsigned CFG_CNT_W  = 8;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_ONE  = 3'd0,
    CFG_DUTY_ONE    = 3'd1,
    CFG_PULSES_ONE  = 3'd2,
    CFG_PERIOD_ZERO = 3'd3,
    CFG_DUTY_ZERO   = 3'd4,
    CFG_PULSES_ZERO = 3'd5
  } cfg_idx_e_t;

  localparam logic [CFG_TIME_W-1:0] RST_PERIOD_ONE  = 16'd76;
  localparam logic [CFG_TIME_W-1:0] RST_DUTY_ONE    = 16'd38;
  localparam logic [CFG_CNT_W-1:0]  RST_PULSES_ONE  = 8'd11;
  localparam logic [CFG_TIME_W-1:0] RST_PERIOD_ZERO = 16'd58;
  localparam logic [CFG_TIME_W-1:0] RST_DUTY_ZERO   = 16'd29;
  localparam logic [CFG_CNT_W-1:0]  RST_PULSES_ZERO = 8'd14;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] period_one;
    logic [CFG_TIME_W-1:0] duty_one;
    logic [CFG_CNT_W-1:0]  pulses_one;
    logic [CFG_TIME_W-1:0] period_zero;
    logic [CFG_TIME_W-1:0] duty_zero;
    logic [CFG_CNT_W-1:0]  pulses_zero;
  } cfg_regs_t;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] data_byte;
  } in_item_t;

endpackage

// File: hw/rtl/fpbm_in_if.sv
// Input channel of the FSK pulse-burst modulator.
// Carries valid, ready and the command item; uses fpbm_pkg widths.
`timescale 1ns / 1ps

interface fpbm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [fpbm_pkg::DATA_W-1:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

// File: hw/rtl/fpbm_out_if.sv
// Result channel of the FSK pulse-burst modulator.
// Carries valid, ready and the four status bits of one result item.
`timescale 1ns / 1ps

interface fpbm_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic accepted;
  logic byte_done;

  modport source (output valid, output pin_level, output busy_res,
                  output accepted, output byte_done, input ready);
  modport sink   (input valid, input pin_level, input busy_res,
                  input accepted, input byte_done, output ready);
endinterface

// File: hw/rtl/fpbm_cfg_if.sv
// Configuration write channel of the FSK pulse-burst modulator.
// Carries valid, ready, a register index and write data; uses fpbm_pkg widths.
`timescale 1ns / 1ps

interface fpbm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fpbm_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [fpbm_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: hw/rtl/fpbm_cfg_regs.sv
// Configuration register file of the FSK pulse-burst modulator.
// Depends on fpbm_pkg and fpbm_cfg_if.
`timescale 1ns / 1ps

module fpbm_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  fpbm_cfg_if.sink            cfg_chan,
  output fpbm_pkg::cfg_regs_t cfg_o
);

  fpbm_pkg::cfg_regs_t cfg_r;
  fpbm_pkg::cfg_regs_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg_o          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        fpbm_pkg::CFG_PERIOD_ONE:  cfg_nxt.period_one  = cfg_chan.wdata;
        fpbm_pkg::CFG_DUTY_ONE:    cfg_nxt.duty_one    = cfg_chan.wdata;
        fpbm_pkg::CFG_PULSES_ONE:
          cfg_nxt.pulses_one = cfg_chan.wdata[fpbm_pkg::CFG_CNT_W-1:0];
        fpbm_pkg::CFG_PERIOD_ZERO: cfg_nxt.period_zero = cfg_chan.wdata;
        fpbm_pkg::CFG_DUTY_ZERO:   cfg_nxt.duty_zero   = cfg_chan.wdata;
        fpbm_pkg::CFG_PULSES_ZERO:
          cfg_nxt.pulses_zero = cfg_chan.wdata[fpbm_pkg::CFG_CNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_one  <= fpbm_pkg::RST_PERIOD_ONE;
      cfg_r.duty_one    <= fpbm_pkg::RST_DUTY_ONE;
      cfg_r.pulses_one  <= fpbm_pkg::RST_PULSES_ONE;
      cfg_r.period_zero <= fpbm_pkg::RST_PERIOD_ZERO;
      cfg_r.duty_zero   <= fpbm_pkg::RST_DUTY_ZERO;
      cfg_r.pulses_zero <= fpbm_pkg::RST_PULSES_ZERO;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hw/rtl/fpbm_in_stage.sv
// Input register of the FSK pulse-burst modulator.
// Holds one accepted item until the core takes it; depends on fpbm_pkg and fpbm_in_if.
`timescale 1ns / 1ps

module fpbm_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  fpbm_in_if.sink            in_chan,
  input  logic               take_i,
  output logic               item_valid_o,
  output fpbm_pkg::in_item_t item_o
);

  logic               valid_r;
  logic               valid_nxt;
  fpbm_pkg::in_item_t item_r;
  logic               load;

  assign in_chan.ready = !valid_r || take_i;
  assign load          = in_chan.valid && in_chan.ready;
  assign valid_nxt     = load || (valid_r && !take_i);
  assign item_valid_o  = valid_r;
  assign item_o        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.cmd       <= in_chan.cmd;
      item_r.data_byte <= in_chan.data_byte;
    end
  end

endmodule

// File: hw/rtl/fpbm_core.sv
// Modulator state and result register of the FSK pulse-burst modulator.
// Updates symbol, bit, period and tick counters per item; depends on fpbm_pkg, fpbm_out_if.
`timescale 1ns / 1ps

module fpbm_core #(
  parameter int unsigned BITS_PER_SYMBOL = 8,
  parameter int unsigned TIMER_WIDTH     = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fpbm_pkg::cfg_regs_t cfg_i,
  input  logic                item_valid_i,
  input  fpbm_pkg::in_item_t  item_i,
  output logic                take_o,
  fpbm_out_if.source          out_chan
);

  localparam int unsigned BL_W = $clog2(BITS_PER_SYMBOL + 1);
  localparam int unsigned CW   = fpbm_pkg::CFG_CNT_W;

  logic [BITS_PER_SYMBOL-1:0] shift_r, shift_nxt;
  logic [BL_W-1:0]            bits_left_r, bits_left_nxt;
  logic [CW-1:0]              pulse_r, pulse_nxt;
  logic [TIMER_WIDTH-1:0]     tick_r, tick_nxt;
  logic                       sending_r, sending_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       pin_nxt, accepted_nxt, done_nxt;
  logic                       pin_r, busy_r, accepted_r, done_r;

  logic                       cur_one;
  logic [TIMER_WIDTH-1:0]     top;
  logic [CW-1:0]              need;
  logic [CW-1:0]              pulse_inc;
  logic [TIMER_WIDTH-1:0]     duty_nxt;

  assign take_o   = item_valid_i && (!out_valid_r || out_chan.ready);
  assign cur_one  = shift_r[BITS_PER_SYMBOL-1];
  assign top      = cur_one ? TIMER_WIDTH'(cfg_i.period_one) : TIMER_WIDTH'(cfg_i.period_zero);
  assign need     = cur_one ? cfg_i.pulses_one : cfg_i.pulses_zero;
  assign pulse_inc = pulse_r + CW'(1);

  always_comb begin
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    pulse_nxt     = pulse_r;
    tick_nxt      = tick_r;
    sending_nxt   = sending_r;
    accepted_nxt  = 1'b0;
    done_nxt      = 1'b0;
    if (item_i.cmd == fpbm_pkg::CMD_LOAD) begin
      if (!sending_r) begin
        shift_nxt     = BITS_PER_SYMBOL'(item_i.data_byte);
        bits_left_nxt = BL_W'(BITS_PER_SYMBOL);
        pulse_nxt     = '0;
        tick_nxt      = '0;
        sending_nxt   = 1'b1;
        accepted_nxt  = 1'b1;
      end
    end else if (sending_r) begin
      if (tick_r == top) begin
        tick_nxt  = '0;
        pulse_nxt = pulse_inc;
        if (pulse_inc == need) begin
          pulse_nxt     = '0;
          shift_nxt     = shift_r << 1;
          bits_left_nxt = bits_left_r - BL_W'(1);
          if (bits_left_r == BL_W'(1)) begin
            sending_nxt = 1'b0;
            done_nxt    = 1'b1;
          end
        end
      end else begin
        tick_nxt = tick_r + TIMER_WIDTH'(1);
      end
    end
  end

  assign duty_nxt = shift_nxt[BITS_PER_SYMBOL-1] ? TIMER_WIDTH'(cfg_i.duty_one)
                                                  : TIMER_WIDTH'(cfg_i.duty_zero);
  assign pin_nxt  = sending_nxt && (tick_nxt < duty_nxt);

  assign out_valid_nxt = take_o || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      bits_left_r <= '0;
      pulse_r     <= '0;
      tick_r      <= '0;
      sending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take_o) begin
        shift_r     <= shift_nxt;
        bits_left_r <= bits_left_nxt;
        pulse_r     <= pulse_nxt;
        tick_r      <= tick_nxt;
        sending_r   <= sending_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_o) begin
      pin_r      <= pin_nxt;
      busy_r     <= sending_nxt;
      accepted_r <= accepted_nxt;
      done_r     <= done_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pin_level = pin_r;
  assign out_chan.busy_res  = busy_r;
  assign out_chan.accepted  = accepted_r;
  assign out_chan.byte_done = done_r;

endmodule

// File: hw/rtl/fsk_pulse_burst_modulator_top.sv
// FSK pulse-burst modulator: takes one item per clock unless out_chan.ready holds the result
// back, and returns one result item for each. A load item starts a symbol that is sent MSB
// first; each tick item advances the pulse timer one step and reports the pin level. Each
// result passes through the input register and the result register; the core updates the
// symbol, period and tick counters once per item. The input register lets one new item enter
// while a finished result still waits. Configuration writes are never stalled; indexes past
// the last register are ignored.
// Depends on fpbm_pkg, the three channel interfaces, fpbm_cfg_regs, fpbm_in_stage, fpbm_core.
`timescale 1ns / 1ps

module fsk_pulse_burst_modulator_top #(
  parameter int unsigned BITS_PER_SYMBOL = 8,
  parameter int unsigned TIMER_WIDTH     = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  fpbm_in_if.sink    in_chan,
  fpbm_out_if.source out_chan,
  fpbm_cfg_if.sink   cfg_chan
);

  fpbm_pkg::cfg_regs_t cfg;
  fpbm_pkg::in_item_t  item;
  logic                item_valid;
  logic                take;

  fpbm_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg_o    (cfg)
  );

  fpbm_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  fpbm_core #(
    .BITS_PER_SYMBOL (BITS_PER_SYMBOL),
    .TIMER_WIDTH     (TIMER_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_chan     (out_chan)
  );

endmodule

// File: tb/fpbm_result_checker.sv
// Result checker for the FSK pulse-burst modulator: watches the three channels, keeps its
// own copy of the modulator state and registers, and compares every result item.
// Depends on fpbm_pkg and the in, out and cfg channel interfaces.
`timescale 1ns / 1ps

module fpbm_result_checker #(
  parameter int unsigned BITS_PER_SYMBOL = 8,
  parameter int unsigned TIMER_WIDTH     = 16
) (
  input  logic clk,
  input  logic rst_n,
  fpbm_in_if   in_mon,
  fpbm_out_if  out_mon,
  fpbm_cfg_if  cfg_mon,
  output int   fail_count,
  output int   outstanding,
  output logic sym_busy,
  output int   items_seen,
  output int   loads_refused,
  output int   symbols_sent
);
  import fpbm_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic accepted;
    logic byte_done;
  } status_t;

  cfg_regs_t                  regs;
  logic [BITS_PER_SYMBOL-1:0] sym_bits;
  int unsigned                bits_to_go;
  logic [CFG_CNT_W-1:0]       periods_done;
  logic [TIMER_WIDTH-1:0]     timer;
  logic                       sending;
  status_t                    expected_status_q[$];
  int                         n_fail    = 0;
  int                         n_items   = 0;
  int                         n_refused = 0;
  int                         n_symbols = 0;

  function automatic status_t step_modulator(input logic cmd, input logic [DATA_W-1:0] data);
    status_t                res;
    logic                   one;
    logic [TIMER_WIDTH-1:0] period_top;
    logic [TIMER_WIDTH-1:0] duty;
    logic [CFG_CNT_W-1:0]   need;
    res = '0;
    if (cmd == CMD_LOAD) begin
      if (!sending) begin
        sym_bits     = BITS_PER_SYMBOL'(data);
        bits_to_go   = BITS_PER_SYMBOL;
        periods_done = '0;
        timer        = '0;
        sending      = 1'b1;
        res.accepted = 1'b1;
      end
    end else if (sending) begin
      one        = sym_bits[BITS_PER_SYMBOL-1];
      period_top = TIMER_WIDTH'(one ? regs.period_one : regs.period_zero);
      need       = one ? regs.pulses_one : regs.pulses_zero;
      if (timer == period_top) begin
        timer        = '0;
        periods_done = periods_done + 1'b1;
        if (periods_done == need) begin
          periods_done = '0;
          sym_bits     = sym_bits << 1;
          bits_to_go   = bits_to_go - 1;
          if (bits_to_go == 0) begin
            sending       = 1'b0;
            res.byte_done = 1'b1;
          end
        end
      end else begin
        timer = timer + 1'b1;
      end
    end
    duty = TIMER_WIDTH'(sym_bits[BITS_PER_SYMBOL-1] ? regs.duty_one : regs.duty_zero);
    res.pin_level = sending && (timer < duty);
    res.busy_res  = sending;
    return res;
  endfunction

  always @(posedge clk) begin : watch_channels
    status_t want;
    status_t got;
    if (!rst_n) begin
      regs = '{period_one: RST_PERIOD_ONE, duty_one: RST_DUTY_ONE,
               pulses_one: RST_PULSES_ONE, period_zero: RST_PERIOD_ZERO,
               duty_zero: RST_DUTY_ZERO, pulses_zero: RST_PULSES_ZERO};
      sym_bits     = '0;
      bits_to_go   = 0;
      periods_done = '0;
      timer        = '0;
      sending      = 1'b0;
      expected_status_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_e_t'(cfg_mon.reg_index))
          CFG_PERIOD_ONE:  regs.period_one  = cfg_mon.wdata;
          CFG_DUTY_ONE:    regs.duty_one    = cfg_mon.wdata;
          CFG_PULSES_ONE:  regs.pulses_one  = cfg_mon.wdata[CFG_CNT_W-1:0];
          CFG_PERIOD_ZERO: regs.period_zero = cfg_mon.wdata;
          CFG_DUTY_ZERO:   regs.duty_zero   = cfg_mon.wdata;
          CFG_PULSES_ZERO: regs.pulses_zero = cfg_mon.wdata[CFG_CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        want = step_modulator(in_mon.cmd, in_mon.data_byte);
        expected_status_q.push_back(want);
        n_items++;
        if (in_mon.cmd == CMD_LOAD && !want.accepted) n_refused++;
        if (want.byte_done) n_symbols++;
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.pin_level, out_mon.busy_res, out_mon.accepted, out_mon.byte_done};
        if (expected_status_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: result item with none pending: pin=%b busy=%b acc=%b done=%b",
                     $realtime, got.pin_level, got.busy_res, got.accepted, got.byte_done);
        end else begin
          want = expected_status_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
              $display("%0t: mismatch pin=%b/%b busy=%b/%b acc=%b/%b done=%b/%b (exp/got)",
                       $realtime, want.pin_level, got.pin_level, want.busy_res, got.busy_res,
                       want.accepted, got.accepted, want.byte_done, got.byte_done);
          end
        end
      end
    end
    fail_count    <= n_fail;
    outstanding   <= expected_status_q.size();
    sym_busy      <= sending;
    items_seen    <= n_items;
    loads_refused <= n_refused;
    symbols_sent  <= n_symbols;
  end

endmodule

// File: tb/tb_fsk_pulse_burst_modulator_top.sv
// Testbench top for the FSK pulse-burst modulator: clock, reset, item and register stimulus,
// output pacing and the verdict. Checking is done by fpbm_result_checker.
// Depends on fpbm_pkg, the channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module tb_fsk_pulse_burst_modulator_top;
  import fpbm_pkg::*;

  localparam int unsigned CLK_HIGH        = 6;
  localparam int unsigned CLK_LOW         = 6;
  localparam int unsigned RESET_CYCLES    = 9;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned RAND_PHASES     = 10;
  localparam int unsigned ITEMS_PER_PHASE = 120;
  localparam int unsigned HOLD_PHASE      = 3;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned HOLD_BURST      = 48;
  localparam int          CYCLE_LIMIT     = 400000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef enum int unsigned {
    SINK_OPEN,
    SINK_COIN,
    SINK_PATTERN,
    SINK_SPARSE
  } sink_mode_e;

  logic clk = 1'b0;
  logic rst_n;
  logic hold_req;
  int   cycles = 0;
  int   fail_count;
  int   outstanding;
  logic sym_busy;
  int   items_seen;
  int   loads_refused;
  int   symbols_sent;
  int unsigned burst_left = 0;
  int unsigned nogap_left = 0;

  fpbm_in_if  in_chan();
  fpbm_out_if out_chan();
  fpbm_cfg_if cfg_chan();

  fsk_pulse_burst_modulator_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  fpbm_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_mon       (cfg_chan),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .sym_busy      (sym_busy),
    .items_seen    (items_seen),
    .loads_refused (loads_refused),
    .symbols_sent  (symbols_sent)
  );

  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW  clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : sink_pacing
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    bit          hold_used;
    logic [7:0]  pattern;
    out_chan.ready <= 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    hold_used = 1'b0;
    pattern   = 8'hA5;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode       = sink_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
        pattern    = 8'($urandom);
        pattern[0] = 1'b1;
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:    out_chan.ready <= 1'b1;
          SINK_COIN:    out_chan.ready <= 1'($urandom_range(0, 1));
          SINK_PATTERN: begin
            out_chan.ready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
          default:      out_chan.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_item(input cmd_e_t c, input logic [DATA_W-1:0] d);
    in_chan.valid     <= 1'b1;
    in_chan.cmd       <= c;
    in_chan.data_byte <= d;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic pace_sender();
    int unsigned gap;
    if (nogap_left != 0) begin
      nogap_left--;
      return;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_chan.valid     <= 1'b1;
    cfg_chan.reg_index <= idx;
    cfg_chan.wdata     <= val;
    do @(posedge clk); while (!cfg_chan.ready);
  endtask

  task automatic end_writes();
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_block();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Ticks the current symbol out so that the next settings start from an idle modulator.
  task automatic finish_symbol();
    drain_block();
    while (sym_busy) begin
      pace_sender();
      send_item(CMD_TICK, DATA_W'($urandom));
    end
    drain_block();
  endtask

  function automatic logic [CFG_TIME_W-1:0] pick_period();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_TIME_W'(1);
      default: return CFG_TIME_W'($urandom_range(2, 4));
    endcase
  endfunction

  function automatic logic [CFG_TIME_W-1:0] pick_duty(input logic [CFG_TIME_W-1:0] period);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return CFG_TIME_W'(period + $urandom_range(1, 3));
      3:       return CFG_TIME_W'($urandom);
      default: return CFG_TIME_W'($urandom_range(0, period));
    endcase
  endfunction

  task automatic set_random_config();
    logic [CFG_TIME_W-1:0] per_one;
    logic [CFG_TIME_W-1:0] per_zero;
    per_one  = pick_period();
    per_zero = pick_period();
    write_reg(CFG_PERIOD_ONE, per_one);
    write_reg(CFG_DUTY_ONE, pick_duty(per_one));
    write_reg(CFG_PULSES_ONE,
              CFG_DATA_W'(($urandom_range(0, 4) == 0) ? 3 : $urandom_range(1, 2)));
    write_reg(CFG_PERIOD_ZERO, per_zero);
    write_reg(CFG_DUTY_ZERO, pick_duty(per_zero));
    write_reg(CFG_PULSES_ZERO,
              CFG_DATA_W'(($urandom_range(0, 4) == 0) ? 3 : $urandom_range(1, 2)));
    end_writes();
  endtask

  initial begin : stimulus
    cmd_e_t next_cmd;
    int     ph;
    int     k;
    rst_n              <= 1'b0;
    hold_req           <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.cmd        <= CMD_TICK;
    in_chan.data_byte  <= '0;
    cfg_chan.valid     <= 1'b0;
    cfg_chan.reg_index <= CFG_PERIOD_ONE;
    cfg_chan.wdata     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: idle tick, a load, a refused load, then registers changed mid-symbol.
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_LOAD, 8'hA5);
    send_item(CMD_LOAD, 8'h5A);
    repeat (10) send_item(CMD_TICK, 8'h00);
    drain_block();
    write_reg(CFG_PERIOD_ONE, 16'd12);
    write_reg(CFG_PERIOD_ZERO, 16'd12);
    write_reg(CFG_PULSES_ONE, 16'd1);
    write_reg(CFG_PULSES_ZERO, 16'd1);
    write_reg(CFG_IDX_UNUSED, 16'hFFFF);
    end_writes();
    finish_symbol();

    // One-tick periods, a one bit of 255 periods with duty above the period, zero bits low.
    write_reg(CFG_PERIOD_ONE, 16'd0);
    write_reg(CFG_DUTY_ONE, 16'hFFFF);
    write_reg(CFG_PULSES_ONE, 16'd255);
    write_reg(CFG_PERIOD_ZERO, 16'd0);
    write_reg(CFG_DUTY_ZERO, 16'd0);
    write_reg(CFG_PULSES_ZERO, 16'd1);
    end_writes();
    send_item(CMD_LOAD, 8'h80);
    finish_symbol();

    // A pulse count of zero wraps to 256 periods.
    write_reg(CFG_PULSES_ONE, 16'd1);
    write_reg(CFG_PULSES_ZERO, 16'd0);
    write_reg(CFG_DUTY_ZERO, 16'd1);
    end_writes();
    send_item(CMD_LOAD, 8'h7F);
    finish_symbol();

    // Full-scale period, then shortened to end the running period on the next tick.
    write_reg(CFG_PERIOD_ONE, 16'hFFFF);
    write_reg(CFG_DUTY_ONE, 16'hFFFE);
    end_writes();
    send_item(CMD_LOAD, 8'hFF);
    repeat (4) send_item(CMD_TICK, 8'h55);
    drain_block();
    write_reg(CFG_PERIOD_ONE, 16'd4);
    end_writes();
    finish_symbol();

    write_reg(CFG_PERIOD_ZERO, 16'd1);
    write_reg(CFG_PULSES_ZERO, 16'd2);
    end_writes();
    send_item(CMD_LOAD, 8'h00);
    send_item(CMD_LOAD, 8'h01);
    finish_symbol();

    // Mostly loads into an idle modulator and ticks while it sends, with some noise.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      finish_symbol();
      set_random_config();
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == HOLD_PHASE && k == ITEMS_PER_PHASE / 2) begin
          hold_req <= 1'b1;
          nogap_left = HOLD_BURST;
        end
        pace_sender();
        if (sym_busy)
          next_cmd = ($urandom_range(0, 9) == 0) ? CMD_LOAD : CMD_TICK;
        else
          next_cmd = ($urandom_range(0, 7) == 0) ? CMD_TICK : CMD_LOAD;
        send_item(next_cmd, DATA_W'($urandom));
      end
    end
    finish_symbol();

    $display("Covered %0d items, %0d symbols sent to the end and %0d refused loads,",
             items_seen, symbols_sent, loads_refused);
    $display("over reset, extreme and random settings and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
